>>> src/slac_pkg.sv
// Shared types and constants for the scan list ADC calibrator.
package slac_pkg;

   localparam int RAW_W    = 16;
   localparam int POS_W    = 4;
   localparam int CHAN_W   = 4;
   localparam int RANGE_W  = 2;
   localparam int INDEX_W  = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int RANGES_W   = 48;
   localparam int NUM_RANGES = 4;

   // Reset contents of the configuration registers.
   localparam logic [RANGES_W-1:0]   RANGES_RESET   = 48'h8000_0000_0000;
   localparam logic [CSR_DATA_W-1:0] CHANNELS_RESET = 64'hFEDC_BA98_7654_3210;
   localparam logic [CSR_DATA_W-1:0] CAL_RESET      = 64'h4000_0000_0000_0000;

   // Largest corrected code.
   localparam logic [RAW_W-1:0] CODE_MAX = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCAN_RANGES   = 3'd0,
      CSR_SCAN_CHANNELS = 3'd1,
      CSR_RANGE0_CAL    = 3'd2,
      CSR_RANGE1_CAL    = 3'd3,
      CSR_RANGE2_CAL    = 3'd4,
      CSR_RANGE3_CAL    = 3'd5
   } csr_index_type;

   // One calibration row: unsigned Q2.30 slope and signed Q16.16 offset.
   typedef struct packed {
      logic [31:0]        slope;
      logic signed [31:0] offset;
   } cal_row_type;

endpackage

>>> src/slac_ifs.sv
// Channel interfaces of the scan list ADC calibrator.
interface slac_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_sample;
   logic        restart;

   modport source (output valid, raw_sample, restart, input ready);
   modport sink   (input valid, raw_sample, restart, output ready);
endinterface

interface slac_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] corrected_sample;
   logic [3:0]  channel_number;
   logic [1:0]  range_code;
   logic [3:0]  entry_position;
   logic        end_of_scan;
   logic [31:0] sample_index;

   modport source (output valid, corrected_sample, channel_number, range_code,
                   entry_position, end_of_scan, sample_index, input ready);
   modport sink   (input valid, corrected_sample, channel_number, range_code,
                   entry_position, end_of_scan, sample_index, output ready);
endinterface

interface slac_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/scan_list_adc_calibrator.sv
// Top level of the scan list ADC calibrator: scan list walk, calibration pipeline, registers.
//
//  Channel | Dir | Fields                                         | Word accepted when
//  --------+-----+------------------------------------------------+--------------------
//  req_ch  | in  | raw_sample, restart                            | valid && ready
//  rsp_ch  | out | corrected_sample, channel_number, range_code,  | valid && ready
//          |     | entry_position, end_of_scan, sample_index      |
//  csr_ch  | in  | index, data                                    | valid && ready
//
// Every input word yields one output word through the lookup register and the output register,
// and a new word is taken every cycle while rsp_ch.ready is high: the lookup register feeds
// the single 16x32 multiply-add, rounding and clamp in front of the output register.
// Reset restores the default scan list and calibration rows and clears the position,
// the sample counter and both pipeline stages.
// When rsp_ch.ready is low the output word holds; an empty lookup stage still fills,
// so at most one more input word is taken before req_ch.ready drops.
// The register port is always ready; writes to unused indexes are dropped.
module scan_list_adc_calibrator #(
   parameter int SCAN_ENTRIES = 16
) (
   input  logic       clock,
   input  logic       reset,
   slac_req_if.sink   req_ch,
   slac_rsp_if.source rsp_ch,
   slac_csr_if.sink   csr_ch
);

   localparam logic [slac_pkg::POS_W-1:0] LAST_ENTRY = slac_pkg::POS_W'(SCAN_ENTRIES - 1);

   // Configuration registers.
   logic [slac_pkg::RANGES_W-1:0]   ranges_ff, ranges_in;
   logic [slac_pkg::CSR_DATA_W-1:0] channels_ff, channels_in;
   slac_pkg::cal_row_type           cal_ff [slac_pkg::NUM_RANGES];
   slac_pkg::cal_row_type           cal_in [slac_pkg::NUM_RANGES];

   // Scan state.
   logic [slac_pkg::POS_W-1:0]   scan_pos_ff, scan_pos_in;
   logic [slac_pkg::INDEX_W-1:0] sample_cnt_ff, sample_cnt_in;

   // Lookup stage.
   logic                           s1_valid_ff, s1_valid_in;
   logic [slac_pkg::RAW_W-1:0]     s1_raw_ff, s1_raw_in;
   slac_pkg::cal_row_type          s1_cal_ff, s1_cal_in;
   logic [slac_pkg::CHAN_W-1:0]    s1_chan_ff, s1_chan_in;
   logic [slac_pkg::RANGE_W-1:0]   s1_range_ff, s1_range_in;
   logic [slac_pkg::POS_W-1:0]     s1_pos_ff, s1_pos_in;
   logic                           s1_wrap_ff, s1_wrap_in;
   logic [slac_pkg::INDEX_W-1:0]   s1_index_ff, s1_index_in;

   // Output stage.
   logic                           out_valid_ff, out_valid_in;
   logic [slac_pkg::RAW_W-1:0]     out_corr_ff, out_corr_in;
   logic [slac_pkg::CHAN_W-1:0]    out_chan_ff, out_chan_in;
   logic [slac_pkg::RANGE_W-1:0]   out_range_ff, out_range_in;
   logic [slac_pkg::POS_W-1:0]     out_pos_ff, out_pos_in;
   logic                           out_wrap_ff, out_wrap_in;
   logic [slac_pkg::INDEX_W-1:0]   out_index_ff, out_index_in;

   logic                          req_accept;
   logic                          out_advance;
   logic                          s1_advance;
   logic [slac_pkg::POS_W-1:0]    pos;
   logic [slac_pkg::INDEX_W-1:0]  index;
   logic [5:0]                    desc_sel;
   logic [5:0]                    chan_sel;
   logic [2:0]                    desc;
   logic                          wrap;
   logic [slac_pkg::RAW_W-1:0]    corrected;

   // The output register moves when it is empty or being drained; the lookup
   // stage moves when the output register can take its word.
   assign out_advance  = !out_valid_ff || rsp_ch.ready;
   assign s1_advance   = !s1_valid_ff || out_advance;
   assign req_ch.ready = s1_advance;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // A restart word uses entry zero and index zero itself.
   assign pos   = req_ch.restart ? '0 : scan_pos_ff;
   assign index = req_ch.restart ? '0 : sample_cnt_ff;

   // Entry fields: three bits per entry in the range word, four in the channel word.
   assign desc_sel = 6'({pos, 1'b0}) + 6'(pos);
   assign chan_sel = 6'({pos, 2'b00});
   assign desc     = ranges_ff[desc_sel +: 3];
   assign wrap     = desc[2] || (pos >= LAST_ENTRY);

   always_comb begin
      s1_raw_in   = req_ch.raw_sample;
      s1_range_in = desc[1:0];
      s1_cal_in   = cal_ff[desc[1:0]];
      s1_chan_in  = channels_ff[chan_sel +: 4];
      s1_pos_in   = pos;
      s1_wrap_in  = wrap;
      s1_index_in = index;
      s1_valid_in = s1_valid_ff;
      scan_pos_in   = scan_pos_ff;
      sample_cnt_in = sample_cnt_ff;
      if (s1_advance) begin
         s1_valid_in = req_ch.valid;
      end
      if (req_accept) begin
         scan_pos_in   = wrap ? '0 : pos + 1'b1;
         sample_cnt_in = index + 1'b1;
      end
   end

   slac_calc u_calc (
      .raw_sample (s1_raw_ff),
      .cal        (s1_cal_ff),
      .corrected  (corrected)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_corr_in  = corrected;
      out_chan_in  = s1_chan_ff;
      out_range_in = s1_range_ff;
      out_pos_in   = s1_pos_ff;
      out_wrap_in  = s1_wrap_ff;
      out_index_in = s1_index_ff;
      if (out_advance) begin
         out_valid_in = s1_valid_ff;
      end
   end

   // Register writes must arrive only while no word is in flight; the block does not enforce it.
   always_comb begin
      ranges_in   = ranges_ff;
      channels_in = channels_ff;
      cal_in      = cal_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (slac_pkg::csr_index_type'(csr_ch.index))
            slac_pkg::CSR_SCAN_RANGES:   ranges_in   = csr_ch.data[slac_pkg::RANGES_W-1:0];
            slac_pkg::CSR_SCAN_CHANNELS: channels_in = csr_ch.data;
            slac_pkg::CSR_RANGE0_CAL:    cal_in[0]   = csr_ch.data;
            slac_pkg::CSR_RANGE1_CAL:    cal_in[1]   = csr_ch.data;
            slac_pkg::CSR_RANGE2_CAL:    cal_in[2]   = csr_ch.data;
            slac_pkg::CSR_RANGE3_CAL:    cal_in[3]   = csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ranges_ff     <= slac_pkg::RANGES_RESET;
         channels_ff   <= slac_pkg::CHANNELS_RESET;
         for (int i = 0; i < slac_pkg::NUM_RANGES; i++) begin
            cal_ff[i] <= slac_pkg::CAL_RESET;
         end
         scan_pos_ff   <= '0;
         sample_cnt_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         ranges_ff     <= ranges_in;
         channels_ff   <= channels_in;
         cal_ff        <= cal_in;
         scan_pos_ff   <= scan_pos_in;
         sample_cnt_ff <= sample_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers load whenever their stage moves.
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s1_raw_ff   <= s1_raw_in;
         s1_cal_ff   <= s1_cal_in;
         s1_chan_ff  <= s1_chan_in;
         s1_range_ff <= s1_range_in;
         s1_pos_ff   <= s1_pos_in;
         s1_wrap_ff  <= s1_wrap_in;
         s1_index_ff <= s1_index_in;
      end
      if (out_advance) begin
         out_corr_ff  <= out_corr_in;
         out_chan_ff  <= out_chan_in;
         out_range_ff <= out_range_in;
         out_pos_ff   <= out_pos_in;
         out_wrap_ff  <= out_wrap_in;
         out_index_ff <= out_index_in;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.corrected_sample = out_corr_ff;
   assign rsp_ch.channel_number   = out_chan_ff;
   assign rsp_ch.range_code       = out_range_ff;
   assign rsp_ch.entry_position   = out_pos_ff;
   assign rsp_ch.end_of_scan      = out_wrap_ff;
   assign rsp_ch.sample_index     = out_index_ff;

   // The position never runs past the last entry of the list.
   a_pos_in_list: assert property (@(posedge clock) disable iff (reset)
      scan_pos_ff <= LAST_ENTRY)
      else $error("scan position beyond the list");

   // A restart word starts at entry zero with index zero.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_ch.restart |=> s1_pos_ff == '0 && s1_index_ff == '0)
      else $error("restart word did not start a new scan");

   // The position after a word follows from the entry that word used.
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> scan_pos_ff == (s1_wrap_ff ? '0 : s1_pos_ff + 1'b1))
      else $error("scan position stepped wrongly");

   // The sample counter runs one ahead of the word just taken.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> sample_cnt_ff == s1_index_ff + 1'b1)
      else $error("sample counter stepped wrongly");

endmodule

>>> src/slac_calc.sv
// Gain and offset correction with round half to even and clamp to the code range.
module slac_calc (
   input  logic [slac_pkg::RAW_W-1:0] raw_sample,
   input  slac_pkg::cal_row_type      cal,
   output logic [slac_pkg::RAW_W-1:0] corrected
);

   logic [47:0]        product;
   logic signed [49:0] sum;
   logic [19:0]        whole;
   logic [29:0]        frac;
   logic               round_up;
   logic [19:0]        rounded;

   // Q.30 sum: the offset moves from 16 to 30 fraction bits.
   assign product = raw_sample * cal.slope;
   assign sum = $signed({2'b00, product})
              + $signed({{4{cal.offset[31]}}, cal.offset, 14'b0});

   assign whole = sum[49:30];
   assign frac  = sum[29:0];
   assign round_up = (frac > 30'h2000_0000) || ((frac == 30'h2000_0000) && whole[0]);
   assign rounded  = whole + 20'(round_up);

   always_comb begin
      if (sum[49]) begin
         corrected = '0;
      end else if (rounded > 20'(slac_pkg::CODE_MAX)) begin
         corrected = slac_pkg::CODE_MAX;
      end else begin
         corrected = rounded[15:0];
      end
   end

endmodule

>>> sim/scan_list_adc_calibrator_tb.sv
// Self-checking testbench for the scan list ADC calibrator: directed script, then random phases.
module scan_list_adc_calibrator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCAN_ENTRIES  = 16;
   localparam int RESET_CYCLES  = 12;
   // Idle margin after the last expected word has come back, to be safe.
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES        = 8;
   localparam int PHASE_WORDS   = 200;
   // Watchdog limit on the whole run; this is several times the slowest run.
   localparam int CYCLE_LIMIT   = 400000;

   // Register indexes that the block decodes to nothing.
   localparam logic [slac_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [slac_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // Half of one LSB in the Q.30 fraction of the calibration sum.
   localparam logic [29:0] HALF_LSB = 30'h2000_0000;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_type;

   // One expected output word.
   typedef struct {
      logic [slac_pkg::RAW_W-1:0]   code;
      logic [slac_pkg::CHAN_W-1:0]  channel;
      logic [slac_pkg::RANGE_W-1:0] range_code;
      logic [slac_pkg::POS_W-1:0]   position;
      logic                         eos;
      logic [slac_pkg::INDEX_W-1:0] seq;
   } cal_word_type;

   // One row of the directed script: either a register write or a sample.
   // Where typed is set, the corrected code is the one written in the row.
   typedef struct {
      bit                              is_csr;
      logic [slac_pkg::CSR_IDX_W-1:0]  csr_idx;
      logic [slac_pkg::CSR_DATA_W-1:0] csr_value;
      logic [slac_pkg::RAW_W-1:0]      raw;
      bit                              restart;
      bit                              typed;
      logic [slac_pkg::RAW_W-1:0]      typed_code;
   } script_row_type;

   logic           clock = 1'b0;
   logic           reset;
   logic           sink_ready = 1'b0;
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    stall_hold = 0;

   slac_req_if req_if ();
   slac_rsp_if rsp_if ();
   slac_csr_if csr_if ();

   assign rsp_if.ready = sink_ready;

   scan_list_adc_calibrator #(
      .SCAN_ENTRIES(SCAN_ENTRIES)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_ch(csr_if)
   );

   always #1 clock = ~clock;

   // Our own copy of the block's registers and scan state.
   logic [slac_pkg::RANGES_W-1:0]   ranges_reg;
   logic [slac_pkg::CSR_DATA_W-1:0] channels_reg;
   slac_pkg::cal_row_type           cal_rows [slac_pkg::NUM_RANGES];
   logic [slac_pkg::POS_W-1:0]      scan_pos;
   logic [slac_pkg::INDEX_W-1:0]    sample_count;

   // Words the block still owes us, oldest first.
   cal_word_type pending_words [$];

   int          fail_count    = 0;
   int          words_sent    = 0;
   int          restarts_sent = 0;
   int          scan_wraps    = 0;
   int          half_ties     = 0;
   int          neg_clamps    = 0;
   int          top_clamps    = 0;
   int unsigned cycle_count   = 0;

   // Sender burst control.
   bit gaps_on   = 1'b0;
   int burst_left = 0;

   // The directed script. Positions noted in the comments follow from the scan
   // list that the script loads: entries 0..3 use ranges 0..3, entry 3 is marked.
   localparam int SCRIPT_ROWS = 31;
   script_row_type script [SCRIPT_ROWS] = '{
      // Reset values: unity slope, zero offset, so the code passes straight through.
      '{0, 3'd0, 64'd0, 16'h0000, 0, 1, 16'h0000},
      '{0, 3'd0, 64'd0, 16'hFFFF, 0, 1, 16'hFFFF},
      // A restart in the middle of the list goes back to entry 0.
      '{0, 3'd0, 64'd0, 16'h8000, 1, 1, 16'h8000},
      // Upper bits of the range word are set and must be ignored.
      '{1, slac_pkg::CSR_SCAN_RANGES,   64'hFFFF_0000_0000_0E88, 16'h0, 0, 0, 16'h0},
      '{1, slac_pkg::CSR_SCAN_CHANNELS, 64'h0123_4567_89AB_CDEF, 16'h0, 0, 0, 16'h0},
      // Range 0: unity slope, offset of one half.
      '{1, slac_pkg::CSR_RANGE0_CAL,    64'h4000_0000_0000_8000, 16'h0, 0, 0, 16'h0},
      // Range 1: zero slope, offset of minus one.
      '{1, slac_pkg::CSR_RANGE1_CAL,    64'h0000_0000_FFFF_0000, 16'h0, 0, 0, 16'h0},
      // Range 2: largest slope and largest offset.
      '{1, slac_pkg::CSR_RANGE2_CAL,    64'hFFFF_FFFF_7FFF_FFFF, 16'h0, 0, 0, 16'h0},
      // Range 3: slope of one half, so odd codes land exactly on a tie.
      '{1, slac_pkg::CSR_RANGE3_CAL,    64'h2000_0000_0000_0000, 16'h0, 0, 0, 16'h0},
      // Writes to the unused indexes must change nothing.
      '{1, CSR_SPARE_LO,                64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 0, 0, 16'h0},
      '{1, CSR_SPARE_HI,                64'h0000_0000_0000_0000, 16'h0, 0, 0, 16'h0},
      '{0, 3'd0, 64'd0, 16'h0000, 1, 1, 16'h0000}, // entry 0: 0.5 ties down to 0
      '{0, 3'd0, 64'd0, 16'hFFFF, 0, 1, 16'h0000}, // entry 1: negative sum
      '{0, 3'd0, 64'd0, 16'hFFFF, 0, 1, 16'hFFFF}, // entry 2: clamps high
      '{0, 3'd0, 64'd0, 16'h0001, 0, 1, 16'h0000}, // entry 3: 0.5 ties down, wraps
      '{0, 3'd0, 64'd0, 16'h0001, 0, 1, 16'h0002}, // entry 0: 1.5 ties up
      '{0, 3'd0, 64'd0, 16'h0000, 0, 1, 16'h0000}, // entry 1
      '{0, 3'd0, 64'd0, 16'h0000, 0, 0, 16'h0000}, // entry 2: offset alone
      '{0, 3'd0, 64'd0, 16'h0003, 0, 1, 16'h0002}, // entry 3: 1.5 ties up
      '{0, 3'd0, 64'd0, 16'h0002, 0, 1, 16'h0002}, // entry 0: 2.5 ties down
      '{0, 3'd0, 64'd0, 16'h0005, 0, 1, 16'h0000}, // entry 1
      '{0, 3'd0, 64'd0, 16'h5555, 0, 0, 16'h0000}, // entry 2
      '{0, 3'd0, 64'd0, 16'h0005, 0, 1, 16'h0002}, // entry 3: 2.5 ties down
      // Largest slope with the most negative offset, then zero slope with it,
      // then the smallest nonzero slope.
      '{1, slac_pkg::CSR_RANGE0_CAL,    64'hFFFF_FFFF_8000_0000, 16'h0, 0, 0, 16'h0},
      '{1, slac_pkg::CSR_RANGE1_CAL,    64'h0000_0000_8000_0000, 16'h0, 0, 0, 16'h0},
      '{1, slac_pkg::CSR_RANGE3_CAL,    64'h0000_0001_0000_0000, 16'h0, 0, 0, 16'h0},
      '{0, 3'd0, 64'd0, 16'h0000, 1, 1, 16'h0000}, // entry 0: negative sum
      '{0, 3'd0, 64'd0, 16'hFFFF, 0, 1, 16'h0000}, // entry 1: negative sum
      '{0, 3'd0, 64'd0, 16'h0001, 0, 0, 16'h0000}, // entry 2
      '{0, 3'd0, 64'd0, 16'hFFFF, 0, 1, 16'h0000}, // entry 3: rounds to zero
      '{0, 3'd0, 64'd0, 16'hFFFF, 0, 1, 16'hFFFF}  // entry 0: clamps high
   };

   // Corrected code for one raw code: the exact sum raw*slope + offset is formed in
   // Q.30, negative sums give zero, the rest rounds half to even and clamps at the top.
   function automatic logic [slac_pkg::RAW_W-1:0] calibrated_code(
         logic [slac_pkg::RAW_W-1:0] raw, slac_pkg::cal_row_type row);
      longint      acc;
      longint      whole;
      logic [29:0] frac;
      acc = longint'(raw) * longint'(row.slope) + longint'($signed(row.offset)) * 64'sd16384;
      if (acc < 0) begin
         neg_clamps++;
         return '0;
      end
      whole = acc >>> 30;
      frac  = acc[29:0];
      if (frac == HALF_LSB)
         half_ties++;
      if (frac > HALF_LSB || (frac == HALF_LSB && whole[0]))
         whole++;
      if (whole > longint'(slac_pkg::CODE_MAX)) begin
         top_clamps++;
         return slac_pkg::CODE_MAX;
      end
      return whole[slac_pkg::RAW_W-1:0];
   endfunction

   // Works out the output word for one accepted input word and advances the scan state.
   function automatic cal_word_type predict_word(logic [slac_pkg::RAW_W-1:0] raw,
                                                 logic restart);
      cal_word_type w;
      logic [2:0]   desc;
      if (restart) begin
         scan_pos     = '0;
         sample_count = '0;
         restarts_sent++;
      end
      desc         = ranges_reg[3*scan_pos +: 3];
      w.range_code = desc[1:0];
      w.eos        = desc[2] || (scan_pos >= SCAN_ENTRIES - 1);
      w.channel    = channels_reg[4*scan_pos +: 4];
      w.position   = scan_pos;
      w.seq        = sample_count;
      w.code       = calibrated_code(raw, cal_rows[desc[1:0]]);
      scan_pos     = w.eos ? '0 : scan_pos + 1'b1;
      sample_count = sample_count + 1'b1;
      words_sent++;
      if (w.eos)
         scan_wraps++;
      return w;
   endfunction

   // Takes the sender idle and waits until every expected word has come back.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write. The valid stays high when another write follows at once.
   task automatic write_csr(logic [slac_pkg::CSR_IDX_W-1:0] idx,
                            logic [slac_pkg::CSR_DATA_W-1:0] value, bit more);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      if (!more)
         csr_if.valid <= 1'b0;
      case (idx)
         slac_pkg::CSR_SCAN_RANGES:   ranges_reg   = value[slac_pkg::RANGES_W-1:0];
         slac_pkg::CSR_SCAN_CHANNELS: channels_reg = value;
         slac_pkg::CSR_RANGE0_CAL:    cal_rows[0]  = value;
         slac_pkg::CSR_RANGE1_CAL:    cal_rows[1]  = value;
         slac_pkg::CSR_RANGE2_CAL:    cal_rows[2]  = value;
         slac_pkg::CSR_RANGE3_CAL:    cal_rows[3]  = value;
         default: ;
      endcase
   endtask

   // Offers one sample word. When bursts are on, an idle gap
   // comes before the first word of each burst.
   task automatic send_word(logic [slac_pkg::RAW_W-1:0] raw, logic restart, bit typed,
                            logic [slac_pkg::RAW_W-1:0] typed_code);
      cal_word_type want;
      if (gaps_on) begin
         if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_if.valid      <= 1'b1;
      req_if.raw_sample <= raw;
      req_if.restart    <= restart;
      do @(posedge clock); while (!req_if.ready);
      want = predict_word(raw, restart);
      if (typed)
         want.code = typed_code;
      pending_words.push_back(want);
   endtask

   // The receiver has its own stall pattern, set per phase: always ready,
   // a random stall on about a quarter of the cycles, or long alternating stretches.
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         case (stall_mode)
            STALL_NONE:   sink_ready <= 1'b1;
            STALL_RANDOM: sink_ready <= ($urandom_range(0, 3) != 0);
            default: begin
               sink_ready <= !sink_ready;
               stall_hold <= sink_ready ? $urandom_range(0, 10) : $urandom_range(0, 4);
            end
         endcase
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Every output word taken from the block is compared with the oldest expectation.
   always @(posedge clock) begin
      cal_word_type want;
      if (!reset && rsp_if.valid && sink_ready) begin
         if (pending_words.size() == 0) begin
            $error("Output word arrived with no expected word pending");
            fail_count++;
         end else begin
            want = pending_words.pop_front();
            check_field("corrected_sample", 32'(want.code),
                        32'(rsp_if.corrected_sample));
            check_field("channel_number",   32'(want.channel),
                        32'(rsp_if.channel_number));
            check_field("range_code",       32'(want.range_code),
                        32'(rsp_if.range_code));
            check_field("entry_position",   32'(want.position),
                        32'(rsp_if.entry_position));
            check_field("end_of_scan",      32'(want.eos),
                        32'(rsp_if.end_of_scan));
            check_field("sample_index",     want.seq, rsp_if.sample_index);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped after %0d cycles with %0d words outstanding",
               cycle_count, pending_words.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int                              phase;
      int                              item;
      int                              entry;
      int                              r;
      int                              odds;
      bit                              more;
      logic [slac_pkg::CSR_DATA_W-1:0] ranges_word;
      logic [slac_pkg::CSR_DATA_W-1:0] chan_word;
      logic [31:0]                     slope;
      logic [31:0]                     offset;
      logic [2:0]                      desc;
      logic [slac_pkg::RAW_W-1:0]      raw;
      bit                              restart;

      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.raw_sample <= '0;
      req_if.restart    <= 1'b0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= '0;
      csr_if.data       <= '0;

      // Reset state of our copy of the block.
      ranges_reg   = slac_pkg::RANGES_RESET;
      channels_reg = slac_pkg::CHANNELS_RESET;
      for (r = 0; r < slac_pkg::NUM_RANGES; r++)
         cal_rows[r] = slac_pkg::CAL_RESET;
      scan_pos     = '0;
      sample_count = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed script. Register writes only go out once the block is idle.
      gaps_on = 1'b1;
      for (r = 0; r < SCRIPT_ROWS; r++) begin
         if (script[r].is_csr) begin
            if (r == 0 || !script[r-1].is_csr)
               settle();
            more = (r + 1 < SCRIPT_ROWS) && script[r+1].is_csr;
            write_csr(script[r].csr_idx, script[r].csr_value, more);
         end else begin
            send_word(script[r].raw, script[r].restart, script[r].typed, script[r].typed_code);
         end
      end

      // Random phases. The first two load every register with all ones and then
      // all zeros; the rest use random scan lists and a mix of calibration rows.
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         gaps_on = (phase % 3 != 0);
         case (phase % 4)
            0:       stall_mode <= STALL_NONE;
            1, 3:    stall_mode <= STALL_RANDOM;
            default: stall_mode <= STALL_LONG;
         endcase

         if (phase == 0) begin
            // Every entry marked and on range 3, so the scan never leaves entry 0.
            ranges_word = '1;
            chan_word   = '1;
         end else if (phase == 1) begin
            // No marks at all, so the scan runs through entry 15 and wraps there.
            ranges_word = '0;
            chan_word   = '0;
         end else begin
            // Mark density varies from none to about every other entry.
            odds        = $urandom_range(0, 2);
            ranges_word = {$urandom(), $urandom()};
            for (entry = 0; entry < SCAN_ENTRIES; entry++) begin
               desc[1:0] = 2'($urandom_range(0, 3));
               desc[2]   = (odds != 0) && ($urandom_range(0, (odds == 1) ? 5 : 1) == 0);
               ranges_word[3*entry +: 3] = desc;
            end
            chan_word = {$urandom(), $urandom()};
         end
         write_csr(slac_pkg::CSR_SCAN_RANGES, ranges_word, 1'b1);
         write_csr(slac_pkg::CSR_SCAN_CHANNELS, chan_word, 1'b1);

         for (r = 0; r < slac_pkg::NUM_RANGES; r++) begin
            if (phase == 0) begin
               slope  = '1;
               offset = '1;
            end else if (phase == 1) begin
               slope  = '0;
               offset = '0;
            end else begin
               case ($urandom_range(0, 4))
                  0: begin
                     // Near unity gain with a modest offset, the usual real case.
                     slope  = 32'h4000_0000 + $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
                     offset = $urandom_range(0, 32'h0FA0_0000) - 32'h07D0_0000;
                  end
                  1: begin
                     // Slopes in eighths and offsets in halves, so ties come up often.
                     slope  = $urandom_range(0, 16) << 27;
                     offset = ($urandom_range(0, 800) - 400) << 15;
                  end
                  2: begin
                     slope  = $urandom();
                     offset = $urandom();
                  end
                  3: begin
                     slope  = $urandom();
                     offset = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                  end
                  default: begin
                     slope  = $urandom_range(32'h3800_0000, 32'h4800_0000);
                     offset = '0;
                  end
               endcase
            end
            more = (r != slac_pkg::NUM_RANGES - 1) || (phase >= 2);
            write_csr(slac_pkg::csr_index_type'(slac_pkg::CSR_RANGE0_CAL + r),
                      {slope, offset}, more);
         end
         if (phase >= 2)
            write_csr((phase % 2) ? CSR_SPARE_HI : CSR_SPARE_LO, {$urandom(), $urandom()}, 1'b0);

         for (item = 0; item < PHASE_WORDS; item++) begin
            // Once, the sender holds back until the block has delivered everything.
            if (phase == 3 && item == PHASE_WORDS / 2)
               settle();
            if ($urandom_range(0, 3) != 0) begin
               raw = 16'($urandom_range(0, 16'hFFFF));
            end else begin
               case ($urandom_range(0, 5))
                  0:       raw = 16'h0000;
                  1:       raw = 16'h0001;
                  2:       raw = 16'h7FFF;
                  3:       raw = 16'h8000;
                  4:       raw = 16'hFFFE;
                  default: raw = 16'hFFFF;
               endcase
            end
            restart = ($urandom_range(0, 39) == 0);
            send_word(raw, restart, 1'b0, '0);
         end
      end

      settle();

      $display("Covered %0d sample words over %0d register settings, %0d restarts, %0d scan wraps.",
               words_sent, PHASES + 3, restarts_sent, scan_wraps);
      $display("Rounding ties %0d, negative sums %0d, clamps at full scale %0d.",
               half_ties, neg_clamps, top_clamps);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> scan_list_adc_calibrator.f
src/slac_pkg.sv
src/slac_ifs.sv
src/slac_calc.sv
src/scan_list_adc_calibrator.sv
sim/scan_list_adc_calibrator_tb.sv
